@@ design/lbp_pkg.sv @@
package lbp_pkg;

    // Field widths of the item and result channels.
    localparam int PIX_W      = 8;
    localparam int BIN_W      = 8;
    localparam int COUNT_W    = 20;
    localparam int BIN_COUNT  = 256;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - COUNT_W - PIX_W;

    // Frame geometry limits and reset values.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_DIM       = 3;
    localparam int RESET_WIDTH   = 64;
    localparam int RESET_HEIGHT  = 64;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int HGT_W         = $clog2(MAX_HEIGHT + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Request kinds carried in tuser.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Saturation limit of one histogram bin.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Neighbour offsets (row, column) for code bits 0 to 7.
    localparam int NB_ROW [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
    localparam int NB_COL [8] = '{1, 1, 1, 0, -1, -1, -1, 0};

    // One classified request as it travels from front to back.
    typedef struct packed {
        logic             is_read;
        logic             clear;
        logic             code_valid;
        logic [PIX_W-1:0] code;
        logic             frame_done;
        logic [BIN_W-1:0] addr;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ design/lbp_front.sv @@
module lbp_front #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_command,
    input  logic [lbp_pkg::PIX_W-1:0]      i_pixel,
    input  logic [lbp_pkg::BIN_W-1:0]      i_bin_index,
    input  logic                           i_queue_full,
    output logic                           o_push,
    output lbp_pkg::t_item                 o_item
);
    import lbp_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW_W  = (WID_W > CFG_DATA_W) ? WID_W : CFG_DATA_W;
    localparam int CMPH_W  = (HGT_W > CFG_DATA_W) ? HGT_W : CFG_DATA_W;
    localparam int RST_WID = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_win [3][3];
    logic [PIX_W-1:0] n_win [3][3];
    logic [PIX_W-1:0] r_line1 [MAX_WIDTH];
    logic [PIX_W-1:0] r_line2 [MAX_WIDTH];
    logic [PIX_W-1:0] r_l1_rd, r_l2_rd;

    logic [CMPW_W-1:0] cfg_ext_w;
    logic [CMPH_W-1:0] cfg_ext_h;
    logic [WID_W-1:0]  cfg_width;
    logic [HGT_W-1:0]  cfg_height;
    logic              cfg_w_hit, cfg_h_hit;
    logic              pix_acc, col_last, row_last, interior, is_read;
    logic [PIX_W-1:0]  centre, code;
    logic [COL_W-1:0]  rd_addr;

    // Configuration is always taken; values are clamped into range on write.
    assign o_cfg_ready = 1'b1;
    assign cfg_w_hit   = i_cfg_valid && (i_cfg_index == REG_IMAGE_WIDTH);
    assign cfg_h_hit   = i_cfg_valid && (i_cfg_index == REG_IMAGE_HEIGHT);
    assign cfg_ext_w   = CMPW_W'(i_cfg_data);
    assign cfg_ext_h   = CMPH_W'(i_cfg_data);

    always_comb begin
        if (cfg_ext_w < CMPW_W'(MIN_DIM)) begin
            cfg_width = WID_W'(MIN_DIM);
        end else if (cfg_ext_w > CMPW_W'(MAX_WIDTH)) begin
            cfg_width = WID_W'(MAX_WIDTH);
        end else begin
            cfg_width = WID_W'(cfg_ext_w);
        end
        if (cfg_ext_h < CMPH_W'(MIN_DIM)) begin
            cfg_height = HGT_W'(MIN_DIM);
        end else if (cfg_ext_h > CMPH_W'(MAX_HEIGHT)) begin
            cfg_height = HGT_W'(MAX_HEIGHT);
        end else begin
            cfg_height = HGT_W'(cfg_ext_h);
        end
    end

    // Requests are taken whenever the queue has room.
    assign o_ready  = !i_queue_full;
    assign o_push   = i_valid && o_ready;
    assign is_read  = (i_command == CMD_READ);
    assign pix_acc  = o_push && !is_read;
    assign col_last = (WID_W'(r_col) + WID_W'(1)) >= r_width;
    assign row_last = (HGT_W'(r_row) + HGT_W'(1)) >= r_height;
    assign interior = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));

    // Raster position; a register write restarts the frame.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (cfg_w_hit || cfg_h_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (pix_acc) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // Window shifts left by one column; the new column comes from the line stores and the incoming pixel.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = r_l2_rd;
        n_win[1][2] = r_l1_rd;
        n_win[2][2] = i_pixel;
    end

    // The centre is the middle of the shifted window.
    assign centre = r_win[1][2];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            code[k] = centre >= n_win[1 + NB_ROW[k]][1 + NB_COL[k]];
        end
    end

    // Classified request towards the back part.
    always_comb begin
        o_item.is_read    = is_read;
        o_item.clear      = !is_read && (r_row == '0) && (r_col == '0);
        o_item.code_valid = !is_read && interior;
        o_item.code       = (!is_read && interior) ? code : '0;
        o_item.frame_done = !is_read && col_last && row_last;
        o_item.addr       = is_read ? i_bin_index : ((!is_read && interior) ? code : '0);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(RST_WID);
            r_height <= HGT_W'(RESET_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            if (cfg_w_hit) begin
                r_width <= cfg_width;
            end
            if (cfg_h_hit) begin
                r_height <= cfg_height;
            end
            r_col <= n_col;
            r_row <= n_row;
            if (pix_acc) begin
                r_win <= n_win;
            end
        end
    end

    // Line stores: the read runs ahead at the column of the next pixel.
    assign rd_addr = i_rst_n ? n_col : '0;

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_line1[r_col] <= i_pixel;
            r_line2[r_col] <= r_l1_rd;
        end
        r_l1_rd <= r_line1[rd_addr];
        r_l2_rd <= r_line2[rd_addr];
    end

endmodule

@@ design/lbp_queue.sv @@
module lbp_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lbp_pkg::t_item        i_item,
    input  logic                  i_pop,
    output lbp_pkg::t_item        o_item,
    output lbp_pkg::t_queue_status o_status
);
    import lbp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_item          = r_slot[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ design/lbp_back.sv @@
module lbp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbp_pkg::t_item               i_item,
    input  lbp_pkg::t_queue_status       i_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_code_valid,
    output logic [lbp_pkg::PIX_W-1:0]    o_lbp_code,
    output logic                         o_frame_done,
    output logic [lbp_pkg::COUNT_W-1:0]  o_bin_count
);
    import lbp_pkg::*;

    logic [COUNT_W-1:0] r_hist [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_bin_vld;
    logic                 r_s2_v;
    t_item                r_s2;
    logic [COUNT_W-1:0]   r_rd_data;
    logic                 r_rd_vld;
    logic                 r_fwd_en, r_fwd_clr;
    logic [BIN_W-1:0]     r_fwd_addr;
    logic [COUNT_W-1:0]   r_fwd_data;
    logic                 r_out_v;
    logic                 r_out_code_valid, r_out_frame_done;
    logic [PIX_W-1:0]     r_out_code;
    logic [COUNT_W-1:0]   r_out_count;

    logic               s2_fire, s2_inc, s2_clr;
    logic [COUNT_W-1:0] old_count, new_count;

    // Handshake between queue, update stage and output register.
    assign s2_fire = r_s2_v && (!r_out_v || i_ready);
    assign o_pop   = !i_status.empty && (!r_s2_v || s2_fire);
    assign s2_inc  = r_s2.code_valid;
    assign s2_clr  = r_s2.clear;

    // Bin value seen by the update stage, including an update or clear
    // that landed in the same cycle as this stage's memory read.
    always_comb begin
        priority if (r_fwd_clr) begin
            old_count = '0;
        end else if (r_fwd_en && (r_fwd_addr == r_s2.addr)) begin
            old_count = r_fwd_data;
        end else if (r_rd_vld) begin
            old_count = r_rd_data;
        end else begin
            old_count = '0;
        end
    end

    // Saturating increment.
    assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);

    // Control state, bin valid flags and bypass flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_bin_vld <= '0;
            r_fwd_en  <= 1'b0;
            r_fwd_clr <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s2_v    <= 1'b1;
                r_fwd_en  <= s2_fire && s2_inc;
                r_fwd_clr <= s2_fire && s2_clr;
            end else if (s2_fire) begin
                r_s2_v <= 1'b0;
            end
            if (s2_fire) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
            if (s2_fire && s2_clr) begin
                r_bin_vld <= '0;
            end else if (s2_fire && s2_inc) begin
                r_bin_vld[r_s2.addr] <= 1'b1;
            end
        end
    end

    // Histogram memory: one write from the update stage, one registered read.
    always_ff @(posedge i_clk) begin
        if (s2_fire && s2_inc) begin
            r_hist[r_s2.addr] <= new_count;
        end
        if (o_pop) begin
            r_rd_data <= r_hist[i_item.addr];
        end
    end

    // Stage and result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2       <= i_item;
            r_rd_vld   <= r_bin_vld[i_item.addr];
            r_fwd_addr <= r_s2.addr;
            r_fwd_data <= new_count;
        end
        if (s2_fire) begin
            r_out_code_valid <= r_s2.code_valid;
            r_out_code       <= r_s2.code;
            r_out_frame_done <= r_s2.frame_done;
            r_out_count      <= r_s2.is_read ? old_count : '0;
        end
    end

    assign o_valid      = r_out_v;
    assign o_code_valid = r_out_code_valid;
    assign o_lbp_code   = r_out_code;
    assign o_frame_done = r_out_frame_done;
    assign o_bin_count  = r_out_count;

endmodule

@@ design/lbp_histogram_extractor_top.sv @@
// Channel   Direction  Handshake                         Payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata: pixel, bin_index; tuser: command
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata: lbp_code, bin_count;
//                                                         tuser: code_valid; tlast: frame_done
// cfg       in         i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// One request per clock is accepted while the queue has room. An accepted request passes
// via a queue slot and the update stage, which holds its bin read, into the result register.
// The rate is set by the histogram memory, which takes one read and one write per cycle.
// Reset clears the histogram at once through per-bin valid flags; no clearing pass is needed.
// A four-entry queue decouples the front from the back, so up to five more requests are
// taken while a result waits on the output register; then tready drops until it is taken.
module lbp_histogram_extractor_top #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [lbp_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,  // [7:0] pixel, [15:8] bin_index
    input  logic                            i_s_axis_tuser,  // [0] command
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [lbp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,  // [7:0] lbp_code, [27:8] bin_count
    output logic                            o_m_axis_tuser,  // [0] code_valid
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lbp_pkg::*;

    t_item         front_item, head_item;
    t_queue_status q_status;
    logic          front_push, back_pop;
    logic [PIX_W-1:0]   out_code;
    logic [COUNT_W-1:0] out_count;

    // Front: frame position, line stores, window and code.
    lbp_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_command   (i_s_axis_tuser),
        .i_pixel     (i_s_axis_tdata[PIX_W-1:0]),
        .i_bin_index (i_s_axis_tdata[PIX_W +: BIN_W]),
        .i_queue_full(q_status.full),
        .o_push      (front_push),
        .o_item      (front_item)
    );

    // Queue between the two parts.
    lbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_item  (head_item),
        .o_status(q_status)
    );

    // Back: histogram update and bin read.
    lbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_status    (q_status),
        .o_pop       (back_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_code_valid(o_m_axis_tuser),
        .o_lbp_code  (out_code),
        .o_frame_done(o_m_axis_tlast),
        .o_bin_count (out_count)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_code};

`ifndef SYNTHESIS
    // The back part never takes from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // The queue is never both full and empty.
    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status inconsistent");

    // A result with a valid code carries no bin count.
    a_code_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[PIX_W +: COUNT_W] == '0)
        else $error("bin count on a code result");

    // Border pixels and bin reads give a zero code.
    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[PIX_W-1:0] == '0)
        else $error("nonzero code without code_valid");
`endif

endmodule

@@ tb/tb_lbp_histogram_extractor_top.sv @@
`timescale 1ns / 100ps

module tb_lbp_histogram_extractor_top;
    import lbp_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int END_WAIT_LIMIT = 20000;
    localparam int RUN_LIMIT_NS   = 5_000_000;
    localparam int RANDOM_ITEMS   = 720;
    localparam int GAP_PERCENT    = 8;

    // An index that selects no register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // One expected response, one member per output field.
    typedef struct packed {
        logic               code_valid;
        logic [PIX_W-1:0]   lbp_code;
        logic               frame_done;
        logic [COUNT_W-1:0] bin_count;
    } t_lbp_result;

    logic                   clk;
    logic                   rst_n;
    logic                   s_valid;
    logic                   s_ready;
    logic [IN_DATA_W-1:0]   s_data;
    logic                   s_user;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_data;
    logic                   m_user;
    logic                   m_last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Mirror of the block state used to predict each response.
    logic [PIX_W-1:0]      line1_img [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]      line2_img [MAX_WIDTH_DEF];
    logic [PIX_W-1:0]      win [3][3];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [COUNT_W-1:0]    bin_totals [BIN_COUNT];
    logic [CFG_DATA_W-1:0] width_cfg;
    logic [CFG_DATA_W-1:0] height_cfg;
    logic [PIX_W-1:0]      recent_code;

    t_lbp_result expected_q [$];
    t_lbp_result head_res;
    t_lbp_result got_res;
    int          error_count = 0;
    bit          gaps_on = 1'b1;

    lbp_histogram_extractor_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Geometry registers are used clamped into the supported range.
    function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // Advance the mirrored state by one request and return its response.
    function automatic t_lbp_result predict_lbp(input logic cmd,
                                                input logic [PIX_W-1:0] px,
                                                input logic [BIN_W-1:0] bin);
        t_lbp_result      res;
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        logic [PIX_W-1:0] nb [8];
        res = '0;
        if (cmd == CMD_READ) begin
            res.bin_count = bin_totals[bin];
            return res;
        end
        w = clamp_dim(width_cfg, MAX_WIDTH_DEF);
        h = clamp_dim(height_cfg, MAX_HEIGHT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;

        // The first pixel of a frame empties the histogram.
        if (r == 0 && c == 0) begin
            foreach (bin_totals[i]) bin_totals[i] = '0;
        end

        // Shift the window left and bring in the new column.
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line2_img[c];
        win[1][2] = line1_img[c];
        win[2][2] = px;
        line2_img[c] = line1_img[c];
        line1_img[c] = px;

        // Neighbours clockwise from top-right; equal values set the bit.
        if (r >= 2 && c >= 2) begin
            nb = '{win[0][2], win[1][2], win[2][2], win[2][1],
                   win[2][0], win[1][0], win[0][0], win[0][1]};
            for (int k = 0; k < 8; k++) res.lbp_code[k] = (win[1][1] >= nb[k]);
            res.code_valid = 1'b1;
            if (bin_totals[res.lbp_code] != COUNT_MAX) bin_totals[res.lbp_code]++;
            recent_code = res.lbp_code;
        end

        if (c + 1 >= w) begin
            c = 0;
            if (r + 1 >= h) begin
                r = 0;
                res.frame_done = 1'b1;
            end else begin
                r++;
            end
        end else begin
            c++;
        end
        col_pos = c;
        row_pos = r;
        return res;
    endfunction

    // Half the reads target the bin of the latest code so that counts are nonzero.
    function automatic logic [BIN_W-1:0] pick_bin();
        return $urandom_range(0, 1) ? recent_code : BIN_W'($urandom);
    endfunction

    // Many pixels come from a narrow band so that equal comparisons are common.
    function automatic logic [PIX_W-1:0] random_pixel();
        return $urandom_range(0, 1) ? PIX_W'($urandom_range(100, 103)) : PIX_W'($urandom);
    endfunction

    // Present one request, wait for it to be taken, then record its response.
    task automatic send_request(input logic cmd, input logic [PIX_W-1:0] px,
                                input logic [BIN_W-1:0] bin);
        t_lbp_result exp_res;
        while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {bin, px};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        exp_res    = predict_lbp(cmd, px, bin);
        expected_q = {expected_q, exp_res};
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        send_request(CMD_PIXEL, px, BIN_W'($urandom));
    endtask

    task automatic send_read(input logic [BIN_W-1:0] bin);
        send_request(CMD_READ, PIX_W'($urandom), bin);
    endtask

    // Hold off new requests until every response is back and the pipe is empty.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                width_cfg = value;
                col_pos   = 0;
                row_pos   = 0;
            end
            REG_IMAGE_HEIGHT: begin
                height_cfg = value;
                col_pos    = 0;
                row_pos    = 0;
            end
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h);
        write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Reset geometry of 64 by 64: three rows give codes on the third one only.
    task automatic test_default_geometry();
        send_read(8'h00);
        send_read(8'hFF);
        for (int i = 0; i < 3 * RESET_WIDTH; i++) begin
            if ($urandom_range(0, 9) == 0) send_read(pick_bin());
            send_pixel(PIX_W'($urandom));
        end
        send_read(recent_code);
    endtask

    // Hand-built 3x3 frames with a known code each.
    task automatic test_directed_codes();
        logic [PIX_W-1:0] mixed [9];
        mixed = '{8'd0, 8'd128, 8'd255, 8'd255, 8'd128, 8'd128, 8'd127, 8'd129, 8'd0};
        set_geometry(3, 3);
        // Centre 128 with equal, larger, smaller and extreme neighbours.
        foreach (mixed[i]) send_pixel(mixed[i]);
        send_read(8'hD6);
        send_read(8'hFF);
        // A flat frame compares equal everywhere, so every bit is set.
        repeat (9) send_pixel(8'hFF);
        send_read(8'hFF);
        send_read(8'hD6);
    endtask

    // Geometry values below three act as three; an unused index changes nothing.
    task automatic test_small_clamped();
        write_register(REG_IMAGE_WIDTH, 11'd0);
        write_register(REG_IMAGE_HEIGHT, 11'd1);
        repeat (9) send_pixel(PIX_W'($urandom));
        send_read(recent_code);
        set_geometry(1, 2);
        repeat (18) send_pixel(random_pixel());
        send_read(recent_code);
        set_geometry(2, 0);
        repeat (9) send_pixel(random_pixel());
        write_register(REG_SPARE, 11'h7FF);
        repeat (9) send_pixel(random_pixel());
        send_read(recent_code);
    endtask

    // A whole frame sent back to back, with no idling on either side.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        set_geometry(20, 10);
        for (int i = 0; i < 20 * 10; i++) begin
            if ($urandom_range(0, 19) == 0) send_read(pick_bin());
            send_pixel(random_pixel());
        end
        send_read(recent_code);
        gaps_on = 1'b1;
    endtask

    // Random small frames with reads mixed in; some frames are abandoned midway.
    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int frames;
        int stop_at;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            set_geometry(w, h);
            // The previous frame's counts survive until the next pixel.
            send_read(pick_bin());
            sent++;
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, w * h - 1) : w * h;
                for (int p = 0; p < stop_at; p++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_read(pick_bin());
                        sent++;
                    end
                    send_pixel(random_pixel());
                    sent++;
                    // Once, let the whole pipeline empty in the middle of a frame.
                    if (!paused && sent > RANDOM_ITEMS / 2) begin
                        wait_drained();
                        paused = 1'b1;
                    end
                end
                if (stop_at < w * h) break;
            end
            send_read(pick_bin());
            sent++;
        end
    endtask

    // Output side accepts with random stalls unless gaps are switched off.
    always @(posedge clk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PERCENT);
    end

    // Compare every accepted response with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            got_res.code_valid = m_user;
            got_res.lbp_code   = m_data[PIX_W-1:0];
            got_res.frame_done = m_last;
            got_res.bin_count  = m_data[PIX_W +: COUNT_W];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected response valid=%b code=%h done=%b count=%0d",
                         $time, got_res.code_valid, got_res.lbp_code,
                         got_res.frame_done, got_res.bin_count);
                error_count++;
            end else begin
                head_res = expected_q.pop_front();
                if (got_res !== head_res) begin
                    $display("%0t: expected valid=%b code=%h done=%b count=%0d",
                             $time, head_res.code_valid, head_res.lbp_code,
                             head_res.frame_done, head_res.bin_count);
                    $display("%0t:   actual valid=%b code=%h done=%b count=%0d",
                             $time, got_res.code_valid, got_res.lbp_code,
                             got_res.frame_done, got_res.bin_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rst_n     <= 1'b0;
        s_valid   <= 1'b0;
        s_user    <= CMD_PIXEL;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;

        // Mirror starts in the reset state.
        foreach (line1_img[i]) begin
            line1_img[i] = '0;
            line2_img[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
        foreach (bin_totals[i]) bin_totals[i] = '0;
        col_pos     = 0;
        row_pos     = 0;
        width_cfg   = CFG_DATA_W'(RESET_WIDTH);
        height_cfg  = CFG_DATA_W'(RESET_HEIGHT);
        recent_code = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_geometry();
        test_directed_codes();
        test_small_clamped();
        test_back_to_back();
        test_random_frames();

        // Let the last responses come back.
        s_valid <= 1'b0;
        for (int n = 0; n < END_WAIT_LIMIT && expected_q.size() != 0; n++) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected responses never arrived", $time, expected_q.size());
        end
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
